### sv/led_fade_effect_sequencer_macros.svh
// Assertion macros for the LED fade effect sequencer.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef LED_FADE_EFFECT_SEQUENCER_MACROS_SVH
`define LED_FADE_EFFECT_SEQUENCER_MACROS_SVH
`ifndef ASSERT_OFF
`define LFES_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LFES_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define LFES_ASSERT(label, clk, rst, prop, msg)
`define LFES_ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

### sv/lfes_pkg.sv
// Shared types and constants of the LED fade effect sequencer.
// No dependencies; used by every module of the block.
`default_nettype none

package lfes_pkg;

   localparam int COLOUR_W   = 8;
   localparam int TOTAL_W    = 16;
   localparam int TICKS_W    = 16;
   localparam int SLOT_W     = 3;
   localparam int MODE_W     = 2;
   localparam int CFG_W      = 4;
   localparam int CSR_ADDR_W = 2;
   localparam int CHANNELS   = 3;

   localparam int DEFAULT_MAX_STEPS = 8;

   // bit-serial divider: one quotient bit per cycle
   localparam int DIV_CNT_W = $clog2(COLOUR_W);

   // request payload layout
   localparam int REQ_DATA_W   = 64;
   localparam int SLOT_LSB     = 0;
   localparam int RED_LSB      = SLOT_LSB + SLOT_W;
   localparam int GREEN_LSB    = RED_LSB + COLOUR_W;
   localparam int BLUE_LSB     = GREEN_LSB + COLOUR_W;
   localparam int TOTAL_LSB    = BLUE_LSB + COLOUR_W;
   localparam int TICKS_LSB    = TOTAL_LSB + TOTAL_W;

   // response payload layout
   localparam int RSP_DATA_W   = 40;
   localparam int LVL_RED_LSB  = 0;
   localparam int LVL_GRN_LSB  = LVL_RED_LSB + COLOUR_W;
   localparam int LVL_BLU_LSB  = LVL_GRN_LSB + COLOUR_W;
   localparam int LVL_MONO_LSB = LVL_BLU_LSB + COLOUR_W;
   localparam int BUSY_BIT     = LVL_MONO_LSB + COLOUR_W;
   localparam int DONE_BIT     = BUSY_BIT + 1;

   // item kinds
   localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_START = 2'd2;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_STEP_COUNT    = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_LOOP_FOREVER  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_MULTI_CHANNEL = 2'd2;

   localparam logic [CFG_W-1:0] STEP_COUNT_RESET = 4'd1;

   // sum/3 as sum*683 >> 11, exact for sums below 2048
   localparam int SUM_W     = COLOUR_W + 2;
   localparam int PROD_W    = 2 * SUM_W;
   localparam logic [SUM_W-1:0] AVG_RECIP = 10'd683;
   localparam int AVG_SHIFT = 11;

   typedef struct packed {
      logic [TICKS_W-1:0]  ticks;
      logic [TOTAL_W-1:0]  total;
      logic [COLOUR_W-1:0] blue;
      logic [COLOUR_W-1:0] green;
      logic [COLOUR_W-1:0] red;
   } step_entry_type;

endpackage

`default_nettype wire

### sv/lfes_step_table.sv
// Step table memory: one write port, one registered read port.
// Depends on lfes_pkg for the entry layout.
`default_nettype none

module lfes_step_table #(
   parameter int MAX_STEPS = lfes_pkg::DEFAULT_MAX_STEPS
) (
   input  logic                                               clock,
   input  logic                                               wr_en,
   input  logic [$clog2((MAX_STEPS > 1) ? MAX_STEPS : 2)-1:0] wr_addr,
   input  lfes_pkg::step_entry_type                           wr_data,
   input  logic [$clog2((MAX_STEPS > 1) ? MAX_STEPS : 2)-1:0] rd_addr,
   output lfes_pkg::step_entry_type                           rd_data
);

   lfes_pkg::step_entry_type mem_ff [MAX_STEPS];
   lfes_pkg::step_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### sv/lfes_serial_div.sv
// Bit-serial restoring divider: 8-bit magnitude by 16-bit divisor,
// one quotient bit per cycle. Depends on lfes_pkg for widths.
`default_nettype none

module lfes_serial_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [lfes_pkg::COLOUR_W-1:0] dividend,
   input  logic [lfes_pkg::TOTAL_W-1:0]  divisor,
   output logic                          done,
   output logic [lfes_pkg::COLOUR_W-1:0] quotient
);

   localparam int CW = lfes_pkg::COLOUR_W;
   localparam int NW = lfes_pkg::DIV_CNT_W;

   logic                             busy_ff;
   logic                             done_ff;
   logic [NW-1:0]                    cnt_ff;
   logic [CW-1:0]                    dvd_ff;   // dividend out on top, quotient in at bottom
   logic [CW-1:0]                    rem_ff;
   logic [lfes_pkg::TOTAL_W-1:0]     divisor_ff;

   logic [CW:0]   rem_sh;
   logic [CW:0]   rem_sub;
   logic          fits;
   logic [CW-1:0] rem_in;

   // partial remainder never exceeds the dividend prefix, so 8 bits hold it
   always_comb begin
      rem_sh  = {rem_ff, dvd_ff[CW-1]};
      fits    = lfes_pkg::TOTAL_W'(rem_sh) >= divisor_ff;
      rem_sub = rem_sh - divisor_ff[CW:0];
      rem_in  = fits ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == '0);
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= NW'(CW - 1);
         end else if (busy_ff) begin
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
            end else begin
               cnt_ff <= cnt_ff - NW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff     <= dividend;
         rem_ff     <= '0;
         divisor_ff <= divisor;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[CW-2:0], fits};
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

`default_nettype wire

### sv/led_fade_effect_sequencer.sv
// LED fade effect sequencer for one LED. Every request transaction returns one
// response with the current levels. Load items and idle ticks go to ST_FINISH,
// which fills the response register; a start first passes the step-table read
// states ST_ARM_WAIT and ST_ARM_LOAD that arm the tick countdown, and a tick
// that takes a fade substep passes ST_SETUP to set up from the table entry,
// ST_DIVIDE in the three bit-serial dividers (one quotient bit per cycle, all
// channels in parallel) and both read states to arm the next countdown; the tick
// that ends a one-shot effect skips the rearm. One item is worked on at a time;
// the response register lets the next request in while a response waits. The step
// table has no reset: start or tick only through entries that have been loaded.
// Depends on lfes_pkg, lfes_step_table, lfes_serial_div and the macro header.
`default_nettype none
`include "led_fade_effect_sequencer_macros.svh"

module led_fade_effect_sequencer #(
   parameter int MAX_STEPS = lfes_pkg::DEFAULT_MAX_STEPS
) (
   input  logic                              clock,
   input  logic                              reset,
   // tdata: step_slot[2:0], target_red[10:3], target_green[18:11],
   //        target_blue[26:19], substep_total[42:27], substep_ticks[58:43]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [lfes_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic [lfes_pkg::MODE_W-1:0]       req_tuser,   // mode[1:0]
   // tdata: level_red[7:0], level_green[15:8], level_blue[23:16],
   //        level_mono[31:24], busy_res[32], effect_done[33]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [lfes_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_we,
   input  logic [lfes_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [lfes_pkg::CFG_W-1:0]        csr_wdata
);

   localparam int AW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
   localparam int CW = $clog2(MAX_STEPS + 1);
   localparam int EW = (CW > lfes_pkg::CFG_W) ? CW : lfes_pkg::CFG_W;
   localparam int LW = lfes_pkg::COLOUR_W;
   localparam int TW = lfes_pkg::TOTAL_W;
   localparam int NC = lfes_pkg::CHANNELS;

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_SETUP    = 6'b000010,
      ST_DIVIDE   = 6'b000100,
      ST_ARM_WAIT = 6'b001000,
      ST_ARM_LOAD = 6'b010000,
      ST_FINISH   = 6'b100000
   } state_type;

   state_type                       state_ff, state_in;
   logic [NC-1:0][LW-1:0]           colour_ff, colour_in;
   logic [AW-1:0]                   step_pos_ff, step_pos_in;
   logic [TW-1:0]                   sub_pos_ff, sub_pos_in;
   logic [lfes_pkg::TICKS_W-1:0]    countdown_ff, countdown_in;
   logic                            active_ff, active_in;
   logic                            done_ff, done_in;
   logic                            last_ff, last_in;
   logic [NC-1:0]                   neg_ff, neg_in;
   logic [lfes_pkg::CFG_W-1:0]      step_count_ff;
   logic                            loop_ff;
   logic                            multi_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [lfes_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                            req_accept;
   logic [lfes_pkg::MODE_W-1:0]     req_mode;
   logic [lfes_pkg::SLOT_W-1:0]     req_slot;
   lfes_pkg::step_entry_type        wr_entry;
   lfes_pkg::step_entry_type        rd_entry;
   logic                            wr_en;

   logic [EW-1:0]                   eff_count;
   logic [EW-1:0]                   step_next;
   logic [lfes_pkg::TICKS_W-1:0]    countdown_dec;
   logic [NC-1:0][LW-1:0]           target;
   logic [NC-1:0][LW-1:0]           div_dvd;
   logic [NC-1:0]                   div_neg;
   logic [NC-1:0][LW-1:0]           div_q;
   logic [NC-1:0]                   div_done;
   logic [TW-1:0]                   left;
   logic                            div_start;
   logic [lfes_pkg::SUM_W-1:0]      sum;
   logic [lfes_pkg::PROD_W-1:0]     prod;

   // ---------------- request unpack and step table ----------------
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign req_mode   = req_tuser;
   assign req_slot   = req_tdata[lfes_pkg::SLOT_LSB +: lfes_pkg::SLOT_W];

   always_comb begin
      wr_entry.red   = req_tdata[lfes_pkg::RED_LSB   +: LW];
      wr_entry.green = req_tdata[lfes_pkg::GREEN_LSB +: LW];
      wr_entry.blue  = req_tdata[lfes_pkg::BLUE_LSB  +: LW];
      wr_entry.total = req_tdata[lfes_pkg::TOTAL_LSB +: TW];
      wr_entry.ticks = req_tdata[lfes_pkg::TICKS_LSB +: lfes_pkg::TICKS_W];
   end

   // slots past the table depth are dropped
   assign wr_en = req_accept && (req_mode == lfes_pkg::MODE_LOAD)
                  && (32'(req_slot) < MAX_STEPS);

   lfes_step_table #(
      .MAX_STEPS (MAX_STEPS)
   ) u_step_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_slot)),
      .wr_data (wr_entry),
      .rd_addr (step_pos_ff),
      .rd_data (rd_entry)
   );

   // ---------------- fade dividers ----------------
   assign target    = {rd_entry.blue, rd_entry.green, rd_entry.red};
   assign div_start = (state_ff == ST_SETUP);
   assign left      = (rd_entry.total > sub_pos_ff) ? (rd_entry.total - sub_pos_ff) : TW'(1);

   always_comb begin
      for (int c = 0; c < NC; c++) begin
         div_neg[c] = target[c] < colour_ff[c];
         div_dvd[c] = div_neg[c] ? (colour_ff[c] - target[c]) : (target[c] - colour_ff[c]);
      end
   end

   for (genvar g = 0; g < NC; g++) begin : g_div
      lfes_serial_div u_div (
         .clock    (clock),
         .reset    (reset),
         .start    (div_start),
         .dividend (div_dvd[g]),
         .divisor  (left),
         .done     (div_done[g]),
         .quotient (div_q[g])
      );
   end

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         step_count_ff <= lfes_pkg::STEP_COUNT_RESET;
         loop_ff       <= 1'b0;
         multi_ff      <= 1'b1;
      end else if (csr_we) begin
         case (csr_addr)
            lfes_pkg::CSR_STEP_COUNT: begin
               step_count_ff <= csr_wdata;
            end
            lfes_pkg::CSR_LOOP_FOREVER: begin
               loop_ff <= csr_wdata[0];
            end
            lfes_pkg::CSR_MULTI_CHANNEL: begin
               multi_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   assign eff_count = (EW'(step_count_ff) > EW'(MAX_STEPS)) ? EW'(MAX_STEPS)
                                                            : EW'(step_count_ff);
   assign step_next = EW'(step_pos_ff) + EW'(1);
   assign countdown_dec = (countdown_ff == '0) ? countdown_ff
                                               : (countdown_ff - lfes_pkg::TICKS_W'(1));

   // ---------------- response levels ----------------
   assign sum  = lfes_pkg::SUM_W'(colour_ff[0]) + lfes_pkg::SUM_W'(colour_ff[1])
               + lfes_pkg::SUM_W'(colour_ff[2]);
   assign prod = lfes_pkg::PROD_W'(sum) * lfes_pkg::PROD_W'(lfes_pkg::AVG_RECIP);

   always_comb begin
      rsp_data_in = '0;
      if (multi_ff) begin
         rsp_data_in[lfes_pkg::LVL_RED_LSB +: LW] = colour_ff[0];
         rsp_data_in[lfes_pkg::LVL_GRN_LSB +: LW] = colour_ff[1];
         rsp_data_in[lfes_pkg::LVL_BLU_LSB +: LW] = colour_ff[2];
      end else begin
         rsp_data_in[lfes_pkg::LVL_MONO_LSB +: LW] = prod[lfes_pkg::AVG_SHIFT +: LW];
      end
      rsp_data_in[lfes_pkg::BUSY_BIT] = active_ff;
      rsp_data_in[lfes_pkg::DONE_BIT] = done_ff;
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in     = state_ff;
      colour_in    = colour_ff;
      step_pos_in  = step_pos_ff;
      sub_pos_in   = sub_pos_ff;
      countdown_in = countdown_ff;
      active_in    = active_ff;
      done_in      = done_ff;
      last_in      = last_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               done_in  = 1'b0;
               state_in = ST_FINISH;
               if (req_mode == lfes_pkg::MODE_START) begin
                  step_pos_in = '0;
                  sub_pos_in  = '0;
                  if (eff_count != '0) begin
                     active_in = 1'b1;
                     state_in  = ST_ARM_WAIT;
                  end else begin
                     active_in    = 1'b0;
                     countdown_in = '0;
                  end
               end else if ((req_mode == lfes_pkg::MODE_TICK) && active_ff) begin
                  countdown_in = countdown_dec;
                  if (countdown_dec == '0) begin
                     state_in = ST_SETUP;
                  end
               end
            end
         end
         ST_SETUP: begin
            // table entry for the current step is in the read register now
            last_in  = ({1'b0, sub_pos_ff} + (TW+1)'(1)) >= {1'b0, rd_entry.total};
            neg_in   = div_neg;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (&div_done) begin
               for (int c = 0; c < NC; c++) begin
                  colour_in[c] = neg_ff[c] ? (colour_ff[c] - div_q[c])
                                           : (colour_ff[c] + div_q[c]);
               end
               state_in = ST_ARM_WAIT;
               if (!last_ff) begin
                  sub_pos_in = sub_pos_ff + TW'(1);
               end else begin
                  sub_pos_in = '0;
                  if (step_next >= eff_count) begin
                     if (loop_ff && (eff_count != '0)) begin
                        step_pos_in = '0;
                     end else begin
                        active_in = 1'b0;
                        done_in   = 1'b1;
                        state_in  = ST_FINISH;
                     end
                  end else begin
                     step_pos_in = step_pos_ff + AW'(1);
                  end
               end
            end
         end
         ST_ARM_WAIT: begin
            state_in = ST_ARM_LOAD;
         end
         ST_ARM_LOAD: begin
            countdown_in = rd_entry.ticks;
            state_in     = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         colour_ff    <= '0;
         step_pos_ff  <= '0;
         sub_pos_ff   <= '0;
         countdown_ff <= '0;
         active_ff    <= 1'b0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         colour_ff    <= colour_in;
         step_pos_ff  <= step_pos_in;
         sub_pos_ff   <= sub_pos_in;
         countdown_ff <= countdown_in;
         active_ff    <= active_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff <= last_in;
      neg_ff  <= neg_in;
      if ((state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_tready)) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------- assertions ----------------
   `LFES_ASSERT_NEXT(a_one_item, clock, reset, req_accept, !req_tready, "second item taken while busy")
   `LFES_ASSERT(a_done_idle, clock, reset, (rsp_tvalid && rsp_tdata[lfes_pkg::DONE_BIT]) |-> !rsp_tdata[lfes_pkg::BUSY_BIT], "effect_done with busy set")
   `LFES_ASSERT(a_step_range, clock, reset, 32'(step_pos_ff) < MAX_STEPS, "step position past table")
   `LFES_ASSERT(a_div_state, clock, reset, (|div_done) |-> (state_ff == ST_DIVIDE), "divider result outside divide state")

endmodule

`default_nettype wire
